FILE: sv/fpsr_pkg.sv
// fpsr_pkg: shared constants and width helpers for the fixed-point square root
// no dependencies; imported by fpsr_stage and fixed_point_square_root_unit

package fpsr_pkg;

	localparam int PAIR_W = 2;

	// result bits for an in_w bit radicand scaled up by frac bits
	function automatic int root_width(input int in_w, input int frac);
		return (in_w + frac + 1) / 2;
	endfunction

endpackage

FILE: sv/fpsr_if.sv
// fpsr_if: valid/ready channels for radicand items in and root items out
// no dependencies; used by fixed_point_square_root_unit

interface fpsr_in_if #(
	parameter int IN_WIDTH = 32
);
	logic                valid;
	logic                ready;
	logic [IN_WIDTH-1:0] radicand;

	modport source (output valid, output radicand, input ready);
	modport sink (input valid, input radicand, output ready);
endinterface

interface fpsr_out_if #(
	parameter int ROOT_WIDTH = 24
);
	logic                  valid;
	logic                  ready;
	logic [ROOT_WIDTH-1:0] root;

	modport source (output valid, output root, input ready);
	modport sink (input valid, input root, output ready);
endinterface

FILE: sv/fixed_point_square_root_unit.sv
// fixed_point_square_root_unit: top level, floor(sqrt(radicand * 2^FRAC_BITS))
// depends on fpsr_pkg, fpsr_if and fpsr_stage
//
//   channel  direction  payload                 accepted when
//   din      in         radicand[IN_WIDTH-1:0]  din.valid && din.ready
//   dout     out        root[ROOT_WIDTH-1:0]    dout.valid && dout.ready
//
// one registered stage per result bit (ROOT_WIDTH bits, 24 by default)
// a new item can enter every cycle while the output is not stalled; throughput is one item per cycle
// a stalled output freezes every stage at once, so nothing is lost or repeated
// reset clears the stage valid bits only; the stage data registers are not reset

module fixed_point_square_root_unit #(
	parameter int FRAC_BITS = 16,
	parameter int IN_WIDTH  = 32
) (
	input logic       clk,
	input logic       arst_n,
	fpsr_in_if.sink   din,
	fpsr_out_if.source dout
);
	import fpsr_pkg::*;

	localparam int ROOT_W = root_width(IN_WIDTH, FRAC_BITS);
	localparam int EW     = 2 * ROOT_W;
	localparam int RW     = ROOT_W + 2;

	logic              adv;
	logic              vld [0:ROOT_W];
	logic [EW-1:0]     ext [0:ROOT_W];
	logic [RW-1:0]     rem [0:ROOT_W];
	logic [ROOT_W-1:0] res [0:ROOT_W];

	assign adv = !vld[ROOT_W] || dout.ready;

	assign vld[0] = din.valid;
	assign ext[0] = EW'({din.radicand, {FRAC_BITS{1'b0}}});
	assign rem[0] = '0;
	assign res[0] = '0;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		fpsr_stage #(
			.ROOT_W (ROOT_W)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (vld[i]),
			.in_ext    (ext[i]),
			.in_rem    (rem[i]),
			.in_res    (res[i]),
			.out_valid (vld[i+1]),
			.out_ext   (ext[i+1]),
			.out_rem   (rem[i+1]),
			.out_res   (res[i+1])
		);
	end

	assign din.ready  = adv;
	assign dout.valid = vld[ROOT_W];
	assign dout.root  = res[ROOT_W];

`ifndef SYNTHESIS
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld[1]) && $stable(vld[ROOT_W-1]) && vld[ROOT_W])
		else $error("pipeline moved while output stalled");

	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld[ROOT_W-1] |=> dout.valid)
		else $error("item lost between last stage and output");

	a_bubble_in: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !din.valid |=> !vld[1])
		else $error("first stage valid without an accepted item");

	a_zero_root: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld[ROOT_W-1] && res[ROOT_W-1] == '0 && rem[ROOT_W-1] == '0
		&& ext[ROOT_W-1] == '0 |=> dout.root == '0)
		else $error("zero radicand gave nonzero root");
`endif

endmodule

FILE: sv/fpsr_stage.sv
// fpsr_stage: one registered step of the radix-2 square root recurrence
// depends on fpsr_pkg; instantiated once per result bit by the top level

module fpsr_stage #(
	parameter int ROOT_W = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [2*ROOT_W-1:0] in_ext,
	input  logic [ROOT_W+1:0]   in_rem,
	input  logic [ROOT_W-1:0]   in_res,
	output logic                out_valid,
	output logic [2*ROOT_W-1:0] out_ext,
	output logic [ROOT_W+1:0]   out_rem,
	output logic [ROOT_W-1:0]   out_res
);
	import fpsr_pkg::*;

	localparam int EW = 2 * ROOT_W;
	localparam int RW = ROOT_W + 2;

	logic              valid_s1;
	logic [EW-1:0]     ext_s1;
	logic [RW-1:0]     rem_s1;
	logic [ROOT_W-1:0] res_s1;

	logic [PAIR_W-1:0] pair;
	logic [RW-1:0]     rem_x;
	logic [RW-1:0]     trial;
	logic              take;

	assign pair  = in_ext[EW-1 -: PAIR_W];
	assign rem_x = {in_rem[ROOT_W-1:0], pair};
	assign trial = {in_res, 2'b01};
	assign take  = rem_x >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ext_s1 <= in_ext << PAIR_W;
			rem_s1 <= take ? rem_x - trial : rem_x;
			res_s1 <= {in_res[ROOT_W-2:0], take};
		end
	end

	assign out_valid = valid_s1;
	assign out_ext   = ext_s1;
	assign out_rem   = rem_s1;
	assign out_res   = res_s1;

endmodule
